/* rtl/wsp_pkg.sv */
// Shared types and constants of the wheel speed controller.
// Used by the top level and the speed divider; no dependencies.
package wsp_pkg;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_STEP  = 10'b0000000010,
    ST_SCALE = 10'b0000000100,
    ST_DIV   = 10'b0000001000,
    ST_CTRL  = 10'b0000010000,
    ST_MULP  = 10'b0000100000,
    ST_MULD  = 10'b0001000000,
    ST_MULIL = 10'b0010000000,
    ST_MULIH = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  localparam logic [1:0] MODE_RELEASE  = 2'd0;
  localparam logic [1:0] MODE_BRAKE    = 2'd1;
  localparam logic [1:0] MODE_FORWARD  = 2'd2;
  localparam logic [1:0] MODE_BACKWARD = 2'd3;

  localparam logic [2:0] REG_TICK   = 3'd0;
  localparam logic [2:0] REG_GPROP  = 3'd1;
  localparam logic [2:0] REG_GINTEG = 3'd2;
  localparam logic [2:0] REG_GDERIV = 3'd3;
  localparam logic [2:0] REG_LIMIT  = 3'd4;

  localparam int NUM_W  = 42;
  localparam int QUO_W  = 23;
  localparam int ACC_W  = 60;

endpackage

/* rtl/wheel_speed_pid_with_stall_detect.sv */
// Wheel speed PID controller with odometer and stall detector, top level.
// Depends on wsp_pkg and wsp_div.
// An item is taken only while the sequencer is idle; it passes the step, scale, divide,
// control, multiply and done states, and its result is registered on the return to idle.
// Braking skips the four multiplies, a saturated speed skips the bit-serial division,
// and a result held by the receiver delays the next acceptance. Synchronous reset
// restores the register defaults and clears all wheel state.
module wheel_speed_pid_with_stall_detect #(
  parameter int WHEEL_COUNT  = 2,
  parameter int DUTY_FULL    = 10000,
  parameter int STALL_WINDOW = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                wheel,
  input  logic [15:0]                         edge_count,
  input  logic [15:0]                         period_ms,
  input  logic signed [15:0]                  target_speed,
  input  logic                                blind_window,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [$clog2(DUTY_FULL+1)-1:0]      duty,
  output logic [1:0]                          drive_mode,
  output logic signed [23:0]                  speed_meas,
  output logic [31:0]                         distance_mm,
  output logic [WHEEL_COUNT-1:0]              stall_flags,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [23:0]                         cfg_data
);

  localparam int DW  = $clog2(DUTY_FULL + 1);
  localparam int WI  = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
  localparam int CW  = $clog2(STALL_WINDOW + 1);
  localparam int AW  = wsp_pkg::ACC_W;

  wsp_pkg::state_t state;

  logic [23:0] tick_length_q16;
  logic [15:0] gain_prop, gain_integ, gain_deriv;
  logic [5:0]  stall_count_limit;

  logic [1:0]                mode_store     [WHEEL_COUNT];
  logic signed [31:0]        prev_error     [WHEEL_COUNT];
  logic signed [39:0]        error_sum      [WHEEL_COUNT];
  logic [DW-1:0]             drive_level    [WHEEL_COUNT];
  logic [23:0]               speed_abs_q8   [WHEEL_COUNT];
  logic [31:0]               distance_whole [WHEEL_COUNT];
  logic [15:0]               distance_frac  [WHEEL_COUNT];
  logic [STALL_WINDOW-1:0]   stall_history  [WHEEL_COUNT];
  logic [CW-1:0]             stall_count    [WHEEL_COUNT];
  logic [WHEEL_COUNT-1:0]    stall_bits;

  logic [WI-1:0]       w;
  logic [15:0]         edges;
  logic [15:0]         period;
  logic signed [15:0]  tgt;
  logic                blind;
  logic [39:0]         step;
  logic                go;
  logic [1:0]          mode;
  logic signed [25:0]  err, derr;
  logic signed [39:0]  sum;
  logic signed [AW-1:0] acc;

  logic [15:0]         mul_a;
  logic signed [25:0]  mul_b;
  logic signed [42:0]  prod;

  logic                         div_start, div_done;
  logic [wsp_pkg::NUM_W-1:0]    div_num;
  logic [wsp_pkg::QUO_W-1:0]    div_quo;

  logic [49:0]  step_k;
  logic [40:0]  total;
  logic [1:0]   want;
  logic [16:0]  tabs;
  logic [23:0]  spd;
  logic signed [25:0] err_c, prev_eff, derr_c;
  logic signed [39:0] sum_eff;
  logic signed [40:0] sum_wide;
  logic signed [39:0] sum_sat;
  logic         differ;
  logic [AW-17:0] u_shift;
  logic [DW-1:0]  lvl;
  logic [DW-1:0]  dl_eff;
  logic           stall_bit;
  logic [STALL_WINDOW-1:0] hist_next;
  logic [CW-1:0]  cnt_next;
  logic           out_free;

  wsp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (period),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall    = (state != wsp_pkg::ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_free    = !out_valid || !out_stall;
  assign stall_flags = stall_bits;

  always_comb begin
    case (state)
      wsp_pkg::ST_STEP: begin
        mul_a = edges;
        mul_b = {2'b0, tick_length_q16};
      end
      wsp_pkg::ST_MULP: begin
        mul_a = gain_prop;
        mul_b = err;
      end
      wsp_pkg::ST_MULD: begin
        mul_a = gain_deriv;
        mul_b = derr;
      end
      wsp_pkg::ST_MULIL: begin
        mul_a = gain_integ;
        mul_b = {6'b0, sum[19:0]};
      end
      wsp_pkg::ST_MULIH: begin
        mul_a = gain_integ;
        mul_b = 26'($signed(sum[39:20]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = $signed({1'b0, mul_a}) * mul_b;

  assign step_k    = ({10'b0, step} << 10) - ({10'b0, step} << 4) - ({10'b0, step} << 3);
  assign div_num   = step_k[49:8];
  assign div_start = (state == wsp_pkg::ST_SCALE);
  assign total     = {1'b0, step} + {25'b0, distance_frac[w]};

  assign want     = tgt[15] ? wsp_pkg::MODE_BACKWARD : wsp_pkg::MODE_FORWARD;
  assign tabs     = tgt[15] ? 17'(-{tgt[15], tgt}) : {1'b0, tgt};
  assign spd      = speed_abs_q8[w];
  assign differ   = (want != mode_store[w]);
  assign err_c    = $signed({1'b0, tabs, 8'h00}) - $signed({2'b0, spd});
  assign prev_eff = differ ? 26'sd0 : prev_error[w][25:0];
  assign sum_eff  = differ ? 40'sd0 : error_sum[w];
  assign derr_c   = err_c - prev_eff;
  assign sum_wide = 41'(sum_eff) + 41'(err_c);
  assign sum_sat  = (sum_wide[40] != sum_wide[39])
                    ? (sum_wide[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}})
                    : sum_wide[39:0];

  assign u_shift = acc[AW-1:16];
  always_comb begin
    if (acc[AW-1] || acc == '0) begin
      lvl = '0;
    end else if (u_shift > (AW-16)'(DUTY_FULL)) begin
      lvl = DW'(DUTY_FULL);
    end else begin
      lvl = u_shift[DW-1:0];
    end
  end

  assign dl_eff    = go ? lvl : drive_level[w];
  assign stall_bit = (dl_eff != '0) && (spd < 24'd256);
  assign hist_next = {stall_history[w][STALL_WINDOW-2:0], stall_bit};
  assign cnt_next  = stall_count[w] + CW'(stall_bit)
                     - CW'(stall_history[w][STALL_WINDOW-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_length_q16   <= 24'd65536;
      gain_prop         <= 16'd2995;
      gain_integ        <= 16'd282;
      gain_deriv        <= 16'd0;
      stall_count_limit <= 6'd25;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsp_pkg::REG_TICK:   tick_length_q16   <= cfg_data;
        wsp_pkg::REG_GPROP:  gain_prop         <= cfg_data[15:0];
        wsp_pkg::REG_GINTEG: gain_integ        <= cfg_data[15:0];
        wsp_pkg::REG_GDERIV: gain_deriv        <= cfg_data[15:0];
        wsp_pkg::REG_LIMIT:  stall_count_limit <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wsp_pkg::ST_IDLE;
      out_valid <= 1'b0;
      stall_bits <= '0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        mode_store[i]     <= wsp_pkg::MODE_RELEASE;
        prev_error[i]     <= '0;
        error_sum[i]      <= '0;
        drive_level[i]    <= '0;
        speed_abs_q8[i]   <= '0;
        distance_whole[i] <= '0;
        distance_frac[i]  <= '0;
        stall_history[i]  <= '0;
        stall_count[i]    <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != wsp_pkg::ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        wsp_pkg::ST_IDLE: begin
          if (in_valid) begin
            w      <= (int'(wheel) >= WHEEL_COUNT) ? WI'(WHEEL_COUNT - 1) : WI'(wheel);
            edges  <= edge_count;
            period <= (period_ms == 16'd0) ? 16'd1 : period_ms;
            tgt    <= target_speed;
            blind  <= blind_window;
            state  <= wsp_pkg::ST_STEP;
          end
        end
        wsp_pkg::ST_STEP: begin
          step  <= prod[39:0];
          state <= wsp_pkg::ST_SCALE;
        end
        wsp_pkg::ST_SCALE: begin
          distance_whole[w] <= distance_whole[w] + 32'(total[40:16]);
          distance_frac[w]  <= total[15:0];
          state <= wsp_pkg::ST_DIV;
        end
        wsp_pkg::ST_DIV: begin
          if (div_done) begin
            speed_abs_q8[w] <= {1'b0, div_quo};
            state <= wsp_pkg::ST_CTRL;
          end
        end
        wsp_pkg::ST_CTRL: begin
          acc <= '0;
          if (tgt == 16'sd0) begin
            go    <= 1'b0;
            mode  <= wsp_pkg::MODE_BRAKE;
            state <= wsp_pkg::ST_DONE;
          end else if (differ && spd > 24'd256) begin
            go    <= 1'b0;
            mode  <= wsp_pkg::MODE_BRAKE;
            state <= wsp_pkg::ST_DONE;
          end else begin
            go            <= 1'b1;
            mode          <= want;
            err           <= err_c;
            derr          <= derr_c;
            sum           <= sum_sat;
            prev_error[w] <= 32'(err_c);
            error_sum[w]  <= sum_sat;
            state         <= wsp_pkg::ST_MULP;
          end
        end
        wsp_pkg::ST_MULP: begin
          acc   <= acc + AW'(prod);
          state <= wsp_pkg::ST_MULD;
        end
        wsp_pkg::ST_MULD: begin
          acc   <= acc + AW'(prod);
          state <= wsp_pkg::ST_MULIL;
        end
        wsp_pkg::ST_MULIL: begin
          acc   <= acc + AW'(prod);
          state <= wsp_pkg::ST_MULIH;
        end
        wsp_pkg::ST_MULIH: begin
          acc   <= acc + (AW'(prod) <<< 20);
          state <= wsp_pkg::ST_DONE;
        end
        wsp_pkg::ST_DONE: begin
          if (out_free) begin
            if (go) begin
              drive_level[w] <= lvl;
            end
            mode_store[w] <= mode;
            if (blind) begin
              stall_history[w] <= '0;
              stall_count[w]   <= '0;
              stall_bits       <= '0;
            end else begin
              stall_history[w] <= hist_next;
              stall_count[w]   <= cnt_next;
              stall_bits[w]    <= ({1'b0, cnt_next} > (CW+1)'(stall_count_limit));
            end
            duty        <= go ? lvl : '0;
            drive_mode  <= mode;
            speed_meas  <= tgt[15] ? -$signed(spd) : $signed(spd);
            distance_mm <= distance_whole[w];
            out_valid   <= 1'b1;
            state       <= wsp_pkg::ST_IDLE;
          end
        end
        default: state <= wsp_pkg::ST_IDLE;
      endcase
    end
  end

  a_brake_no_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_mode == wsp_pkg::MODE_BRAKE |-> duty == '0)
    else $error("duty is not zero while braking");

  a_duty_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty <= DW'(DUTY_FULL))
    else $error("duty above full scale");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == wsp_pkg::ST_STEP)
    else $error("accepted item did not start the sequencer");

endmodule

/* rtl/wsp_div.sv */
// Bit-serial restoring divider for the measured speed, one quotient bit a cycle.
// Depends on wsp_pkg; saturates to all ones when the quotient overflows.
module wsp_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wsp_pkg::NUM_W-1:0]    num,
  input  logic [15:0]                  den,
  output logic                         done,
  output logic [wsp_pkg::QUO_W-1:0]    quo
);

  logic                       busy;
  logic [4:0]                 cnt;
  logic [15:0]                rem;
  logic [wsp_pkg::QUO_W-1:0]  dq;
  logic [16:0]                r2;
  logic [16:0]                r2_sub;
  logic                       ge;

  assign r2     = {rem, dq[wsp_pkg::QUO_W-1]};
  assign ge     = r2 >= {1'b0, den};
  assign r2_sub = r2 - {1'b0, den};
  assign quo    = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num[wsp_pkg::NUM_W-1:wsp_pkg::QUO_W] >= {3'b0, den}) begin
          dq   <= '1;
          done <= 1'b1;
        end else begin
          rem  <= num[wsp_pkg::QUO_W+15:wsp_pkg::QUO_W];
          dq   <= num[wsp_pkg::QUO_W-1:0];
          cnt  <= 5'(wsp_pkg::QUO_W - 1);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? r2_sub[15:0] : r2[15:0];
        dq  <= {dq[wsp_pkg::QUO_W-2:0], ge};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
